### rtl/core/asi_pkg.sv
// ----------------------------------------------------------------------------
// A/B slot selector package
// Shared types and constants for the A/B slot integrity selector.
// ----------------------------------------------------------------------------
`default_nettype none

package asi_pkg;

  // Slot layout and scan limits.
  localparam int unsigned SLOT_COUNT   = 2;
  localparam int unsigned SECTOR_BYTES = 4096;
  localparam int unsigned HDR_BYTES    = 16;
  localparam int unsigned POS_W        = 13;
  localparam int unsigned LEN_W        = 12;

  localparam logic [POS_W-1:0] POS_MAX     = 13'd8191;
  localparam logic [POS_W-1:0] HDR_POS     = 13'd16;

  // FNV-1a-32 constants.
  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  // Configuration register reset values.
  localparam logic [LEN_W-1:0] RESET_LENGTH = 12'd2048;
  localparam logic [31:0]      RESET_MAGIC  = 32'h524D_5653;

  // Configuration register indexes.
  localparam logic CFG_EXPECTED_LENGTH = 1'b0;
  localparam logic CFG_MAGIC_VALUE     = 1'b1;

  // Header word indexes inside the 16-byte header.
  localparam logic [1:0] HW_MAGIC    = 2'd0;
  localparam logic [1:0] HW_SEQUENCE = 2'd1;
  localparam logic [1:0] HW_LENGTH   = 2'd2;
  localparam logic [1:0] HW_HASH     = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_slot;
    logic       start_of_scan;
  } in_item_t;

  typedef struct packed {
    logic        slot_number;
    logic        slot_valid;
    logic [31:0] slot_sequence;
    logic        live_found;
    logic        live_slot;
    logic [31:0] live_sequence;
    logic [31:0] live_hash;
  } out_item_t;

  // Verdict of the slot that ends with the current byte.
  typedef struct packed {
    logic        slot;
    logic        valid;
    logic [31:0] sequence_word;
    logic [31:0] hash_word;
  } slot_status_t;

endpackage

`default_nettype wire

### rtl/core/asi_slot_parser.sv
// ----------------------------------------------------------------------------
// Slot parser
// Captures the slot header, hashes the payload with FNV-1a-32 and judges
// the slot at its final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module asi_slot_parser #(
  parameter int unsigned SECTOR_BYTES = asi_pkg::SECTOR_BYTES
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       go,
  input  wire asi_pkg::in_item_t          item,
  input  wire logic [asi_pkg::LEN_W-1:0]  expected_length,
  input  wire logic [31:0]                magic_value,
  output asi_pkg::slot_status_t           status
);

  localparam logic [asi_pkg::POS_W:0] SECTOR_SIZE = SECTOR_BYTES[asi_pkg::POS_W:0];

  logic [asi_pkg::POS_W-1:0] byte_position;
  logic [31:0]               header_magic;
  logic [31:0]               header_sequence;
  logic [31:0]               header_length;
  logic [31:0]               header_hash;
  logic [31:0]               running_hash;
  logic                      current_slot;

  logic [asi_pkg::POS_W-1:0] pos_base;
  logic [31:0]               magic_base;
  logic [31:0]               seq_base;
  logic [31:0]               len_base;
  logic [31:0]               hash_base;
  logic [31:0]               run_base;
  logic                      slot_base;

  logic [asi_pkg::POS_W-1:0] byte_position_next;
  logic [31:0]               header_magic_next;
  logic [31:0]               header_sequence_next;
  logic [31:0]               header_length_next;
  logic [31:0]               header_hash_next;
  logic [31:0]               running_hash_next;

  logic [31:0]               lane;
  logic [asi_pkg::POS_W-1:0] payload_pos;
  logic [asi_pkg::POS_W-1:0] need;
  logic                      in_header;
  logic                      in_payload;

  // A scan start abandons the slot in progress and starts slot zero afresh.
  always_comb begin
    if (item.start_of_scan) begin
      pos_base   = '0;
      magic_base = '0;
      seq_base   = '0;
      len_base   = '0;
      hash_base  = '0;
      run_base   = asi_pkg::FNV_BASIS;
      slot_base  = 1'b0;
    end else begin
      pos_base   = byte_position;
      magic_base = header_magic;
      seq_base   = header_sequence;
      len_base   = header_length;
      hash_base  = header_hash;
      run_base   = running_hash;
      slot_base  = current_slot;
    end
  end

  // Header capture and payload hashing for the current byte.
  always_comb begin
    in_header   = (pos_base < asi_pkg::HDR_POS);
    payload_pos = pos_base - asi_pkg::HDR_POS;
    in_payload  = !in_header && (payload_pos < {1'b0, expected_length});
    lane        = {24'd0, item.data_byte} << {pos_base[1:0], 3'b000};

    header_magic_next    = magic_base;
    header_sequence_next = seq_base;
    header_length_next   = len_base;
    header_hash_next     = hash_base;
    if (in_header) begin
      case (pos_base[3:2])
        asi_pkg::HW_MAGIC:    header_magic_next    = magic_base | lane;
        asi_pkg::HW_SEQUENCE: header_sequence_next = seq_base | lane;
        asi_pkg::HW_LENGTH:   header_length_next   = len_base | lane;
        default:              header_hash_next     = hash_base | lane;
      endcase
    end

    if (in_payload) begin
      running_hash_next = (run_base ^ {24'd0, item.data_byte}) * asi_pkg::FNV_PRIME;
    end else begin
      running_hash_next = run_base;
    end

    if (pos_base < asi_pkg::POS_MAX) begin
      byte_position_next = pos_base + 1'b1;
    end else begin
      byte_position_next = pos_base;
    end
  end

  // Verdict, meaningful on the final byte of a slot.
  always_comb begin
    need                 = asi_pkg::HDR_POS + {1'b0, expected_length};
    status.slot          = slot_base;
    status.sequence_word = header_sequence_next;
    status.hash_word     = header_hash_next;
    status.valid         = (header_magic_next == magic_value)
                        && (header_length_next == {20'd0, expected_length})
                        && (byte_position_next >= need)
                        && ({1'b0, need} <= SECTOR_SIZE)
                        && (running_hash_next == header_hash_next);
  end

  // Slot state; a slot end starts the next slot index.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      header_magic    <= '0;
      header_sequence <= '0;
      header_length   <= '0;
      header_hash     <= '0;
      running_hash    <= asi_pkg::FNV_BASIS;
      current_slot    <= 1'b0;
    end else if (go) begin
      if (item.end_of_slot) begin
        byte_position   <= '0;
        header_magic    <= '0;
        header_sequence <= '0;
        header_length   <= '0;
        header_hash     <= '0;
        running_hash    <= asi_pkg::FNV_BASIS;
        current_slot    <= ~slot_base;
      end else begin
        byte_position   <= byte_position_next;
        header_magic    <= header_magic_next;
        header_sequence <= header_sequence_next;
        header_length   <= header_length_next;
        header_hash     <= header_hash_next;
        running_hash    <= running_hash_next;
        current_slot    <= slot_base;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/asi_live_tracker.sv
// ----------------------------------------------------------------------------
// Live slot tracker
// Keeps the newest valid slot of the scan and forms the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module asi_live_tracker (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  go,
  input  wire asi_pkg::in_item_t     item,
  input  wire asi_pkg::slot_status_t status,
  output asi_pkg::out_item_t         result
);

  logic        best_found;
  logic        best_index;
  logic [31:0] best_sequence;
  logic [31:0] best_hash;

  logic        found_base;
  logic        slot_base;
  logic [31:0] seq_base;
  logic [31:0] hash_base;

  logic        best_found_next;
  logic        best_index_next;
  logic [31:0] best_sequence_next;
  logic [31:0] best_hash_next;
  logic        take;

  // A scan start clears the tracking; a strictly newer valid slot wins.
  always_comb begin
    if (item.start_of_scan) begin
      found_base = 1'b0;
      slot_base  = 1'b0;
      seq_base   = '0;
      hash_base  = '0;
    end else begin
      found_base = best_found;
      slot_base  = best_index;
      seq_base   = best_sequence;
      hash_base  = best_hash;
    end

    take = item.end_of_slot && status.valid
        && (!found_base || (status.sequence_word > seq_base));

    if (take) begin
      best_found_next    = 1'b1;
      best_index_next    = status.slot;
      best_sequence_next = status.sequence_word;
      best_hash_next     = status.hash_word;
    end else begin
      best_found_next    = found_base;
      best_index_next    = slot_base;
      best_sequence_next = seq_base;
      best_hash_next     = hash_base;
    end
  end

  // Result fields for the slot that ends with this byte.
  always_comb begin
    result.slot_number   = status.slot;
    result.slot_valid    = status.valid;
    result.slot_sequence = status.sequence_word;
    result.live_found    = best_found_next;
    result.live_slot     = best_index_next;
    result.live_sequence = best_sequence_next;
    result.live_hash     = best_hash_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found    <= 1'b0;
      best_index    <= 1'b0;
      best_sequence <= '0;
      best_hash     <= '0;
    end else if (go) begin
      best_found    <= best_found_next;
      best_index    <= best_index_next;
      best_sequence <= best_sequence_next;
      best_hash     <= best_hash_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ab_slot_integrity_selector.sv
// ----------------------------------------------------------------------------
// A/B slot integrity selector
// Checks stored image slots byte by byte and reports the newest valid slot.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one slot byte per
//   transfer, with end_of_slot on the last byte of a slot and start_of_scan
//   on the first byte of slot zero. Output channel (out_valid / out_stall /
//   out_data) carries one result transfer for each byte with end_of_slot set.
//   The configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data)
//   writes expected_length (index 0) and magic_value (index 1); cfg_ready is
//   always high. Write it only while the block is idle.
// Timing:
//   A byte is captured in an input register, then the header capture, the
//   FNV-1a multiply-by-prime and the verdict run combinationally into the
//   result register, from which a result is offered after its last byte has
//   passed the input register. One byte per cycle is sustained while no
//   stalled result holds the result register; one FNV multiply per byte.
// Reset and stall:
//   Reset (synchronous, active high) empties both registers and restores the
//   slot, tracking and configuration state. While out_stall holds a pending
//   result, the next byte waits in the input register and in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module ab_slot_integrity_selector #(
  parameter int unsigned SECTOR_BYTES = asi_pkg::SECTOR_BYTES
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire asi_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output asi_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data
);

  logic [asi_pkg::LEN_W-1:0] expected_length;
  logic [31:0]               magic_value;

  asi_pkg::in_item_t         item_q;
  logic                      item_valid;
  logic                      go;
  logic                      in_take;
  asi_pkg::slot_status_t     status;
  asi_pkg::out_item_t        result;

  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_length <= asi_pkg::RESET_LENGTH;
      magic_value     <= asi_pkg::RESET_MAGIC;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        asi_pkg::CFG_EXPECTED_LENGTH: expected_length <= cfg_data[asi_pkg::LEN_W-1:0];
        asi_pkg::CFG_MAGIC_VALUE:     magic_value     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The held byte is processed whenever the result register can take a result.
  assign go       = item_valid && (!out_valid || !out_stall);
  assign in_stall = item_valid && !go;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (go) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_q <= in_data;
    end
  end

  asi_slot_parser #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_parser (
    .clk             (clk),
    .rst             (rst),
    .go              (go),
    .item            (item_q),
    .expected_length (expected_length),
    .magic_value     (magic_value),
    .status          (status)
  );

  asi_live_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item   (item_q),
    .status (status),
    .result (result)
  );

  // Result register; loaded on the final byte of each slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && item_q.end_of_slot) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && item_q.end_of_slot) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

### rtl/core/asi_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Watches the ports of the A/B slot integrity selector over time.
// ----------------------------------------------------------------------------
`default_nettype none

module asi_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire asi_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire asi_pkg::out_item_t out_data
);

  // A stalled byte stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled byte changed or dropped");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // A valid slot always leaves a live slot behind it.
  a_valid_live: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.slot_valid |-> out_data.live_found)
    else $error("valid slot reported without a live slot");

  // Without a live slot its fields read as zero.
  a_live_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.live_found |->
      !out_data.live_slot && (out_data.live_sequence == 32'd0)
      && (out_data.live_hash == 32'd0))
    else $error("live fields set without a live slot");

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind ab_slot_integrity_selector asi_checker u_asi_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
